[rtl/rmsi_pkg.sv]
// rmsi_pkg: constants and shared types of the running median block
// no dependencies; imported by rmsi_cell, running_median_sorted_insert and the bench
package rmsi_pkg;

    localparam int CAPACITY = 64;
    localparam int SAMPLE_W = 32;
    localparam int MED_W    = SAMPLE_W + 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [IDX_W-1:0]           idx_t;

    // broadcast from the control logic to every cell of the chain
    typedef struct packed {
        logic    load;
        sample_t sample;
        idx_t    idx_lo;
        idx_t    idx_hi;
    } rmsi_bcast_t;

endpackage

[rtl/rmsi_cell.sv]
// rmsi_cell: one slot of the sorted insertion chain
// depends on rmsi_pkg
module rmsi_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rmsi_pkg::idx_t       cell_idx,
    input  rmsi_pkg::rmsi_bcast_t bcast,
    input  logic                 left_gt,
    input  logic                 left_vld,
    input  rmsi_pkg::sample_t    left_val,
    output logic                 gt,
    output logic                 vld,
    output rmsi_pkg::sample_t    val,
    output rmsi_pkg::sample_t    lo_tap,
    output rmsi_pkg::sample_t    hi_tap
);
    import rmsi_pkg::*;

    sample_t val_reg, val_next;
    logic    vld_reg, vld_next;

    // empty slot behaves as +infinity
    assign gt  = !vld_reg || (val_reg > bcast.sample);
    assign vld = vld_reg;
    assign val = val_reg;

    always_comb begin
        val_next = val_reg;
        vld_next = vld_reg;
        if (bcast.load) begin
            vld_next = vld_reg | left_vld;
            if (left_gt) begin
                val_next = left_val;
            end else if (gt) begin
                val_next = bcast.sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        val_reg <= val_next;
    end

    assign lo_tap = (cell_idx == bcast.idx_lo) ? val_reg : '0;
    assign hi_tap = (cell_idx == bcast.idx_hi) ? val_reg : '0;

endmodule

[rtl/running_median_sorted_insert.sv]
// running_median_sorted_insert: running median over a sorted insertion chain
// depends on rmsi_pkg and rmsi_cell
//
// Each accepted sample is placed in a chain of CAPACITY cells that is kept in
// ascending order: in the cycle of the transaction every cell compares its
// entry with the sample and either keeps it, takes the sample, or takes its
// left neighbor's entry, and the cells register the outcome. Once the result
// register is free, the two middle entries are tapped out of the chain, summed
// and registered as the result: median_doubled is twice the median (one
// fraction bit), sample_count the number held. Once CAPACITY samples are held,
// further samples are still taken but refused: overflow is set and the median
// and count stay as they were. With m_ready held high one sample is taken
// every cycle; throughput is set by the cell update followed by the median
// select-and-add stage, which overlap across samples.
module running_median_sorted_insert (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [31:0]        s_sample,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [32:0]        m_median_doubled,
    output logic [6:0]                m_sample_count,
    output logic                      m_overflow
);
    import rmsi_pkg::*;

    // control state
    logic             pend_reg, pend_next;        // cells updated, result not yet formed
    logic             ovf_pend_reg, ovf_pend_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;

    // result payload
    logic signed [MED_W-1:0] median_reg, median_next;
    logic [CNT_W-1:0]        count_out_reg, count_out_next;
    logic                    ovf_reg, ovf_next;

    logic        s_xact, m_xact, full, out_load;
    rmsi_bcast_t bcast;
    idx_t        idx_hi;

    // chain wiring
    logic    gt_vec  [CAPACITY];
    logic    vld_vec [CAPACITY];
    sample_t val_vec [CAPACITY];
    sample_t lo_taps [CAPACITY];
    sample_t hi_taps [CAPACITY];
    logic [CAPACITY-1:0] vld_bits;
    sample_t lo_sel, hi_sel;

    assign full     = (count_reg == CNT_W'(CAPACITY));
    // result register frees up when empty or being drained this cycle
    assign out_load = pend_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !pend_reg || out_load;
    assign s_xact   = s_valid && s_ready;
    assign m_xact   = m_valid_reg && m_ready;

    // middle indexes from the current count (at least one when pending)
    assign idx_hi       = IDX_W'(count_reg >> 1);
    assign bcast.load   = s_xact && !full;
    assign bcast.sample = s_sample;
    assign bcast.idx_hi = idx_hi;
    assign bcast.idx_lo = count_reg[0] ? idx_hi : idx_hi - 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic    l_gt, l_vld;
            sample_t l_val;
            if (gi == 0) begin : g_head
                assign l_gt  = 1'b0;
                assign l_vld = 1'b1;
                assign l_val = '0;
            end else begin : g_body
                assign l_gt  = gt_vec[gi-1];
                assign l_vld = vld_vec[gi-1];
                assign l_val = val_vec[gi-1];
            end
            rmsi_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (IDX_W'(gi)),
                .bcast    (bcast),
                .left_gt  (l_gt),
                .left_vld (l_vld),
                .left_val (l_val),
                .gt       (gt_vec[gi]),
                .vld      (vld_vec[gi]),
                .val      (val_vec[gi]),
                .lo_tap   (lo_taps[gi]),
                .hi_tap   (hi_taps[gi])
            );
            assign vld_bits[gi] = vld_vec[gi];
        end
    endgenerate

    // or together the one-hot taps of the middle entries
    always_comb begin
        lo_sel = '0;
        hi_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            lo_sel = lo_sel | lo_taps[i];
            hi_sel = hi_sel | hi_taps[i];
        end
    end

    always_comb begin
        pend_next      = pend_reg;
        ovf_pend_next  = ovf_pend_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg;
        median_next    = median_reg;
        count_out_next = count_out_reg;
        ovf_next       = ovf_reg;

        if (m_xact) begin
            m_valid_next = 1'b0;
        end
        // result of the pending sample, read before the chain moves again
        if (out_load) begin
            m_valid_next   = 1'b1;
            median_next    = MED_W'(lo_sel) + MED_W'(hi_sel);
            count_out_next = count_reg;
            ovf_next       = ovf_pend_reg;
            pend_next      = 1'b0;
        end
        if (s_xact) begin
            pend_next     = 1'b1;
            ovf_pend_next = full;
            if (!full) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        ovf_pend_reg  <= ovf_pend_next;
        median_reg    <= median_next;
        count_out_reg <= count_out_next;
        ovf_reg       <= ovf_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_median_doubled = median_reg;
    assign m_sample_count   = count_out_reg;
    assign m_overflow       = ovf_reg;

    // occupied cells always match the held count
    a_vld_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(vld_bits) == 32'(count_reg))
        else $error("cell occupancy differs from held count");

    // valid cells form a contiguous run from the head of the chain
    a_vld_thermo: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_bits & ~(vld_bits << 1) & ~CAPACITY'(1)) == '0)
        else $error("gap in occupied cells");

    // a stored sample grows the count by one
    a_count_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !full |=> count_reg == $past(count_reg) + 1'b1)
        else $error("count did not advance on stored sample");

    // a refused sample is only reported with a full store
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_sample_count == CNT_W'(CAPACITY))
        else $error("overflow reported below capacity");

endmodule

[bench/running_median_sorted_insert_tb.sv]
// running_median_sorted_insert_tb: self-checking bench for the running median block
// depends on rmsi_pkg and running_median_sorted_insert; a scoreboard class holds
// its own sorted copy of the samples and checks each median result in order
`timescale 1ns / 1ps

module running_median_sorted_insert_tb;
    import rmsi_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1775;
    localparam int LONG_HOLD    = 300;   // receiver stall that fills the block
    localparam int TAIL_CYCLES  = 10;
    localparam int CYCLE_LIMIT  = 400000;

    // one expected result transaction
    typedef struct {
        logic signed [MED_W-1:0] median_doubled;
        logic [CNT_W-1:0]        sample_count;
        logic                    overflow;
    } median_result_t;

    // keeps a sorted copy of the held samples and the results still owed
    class median_scoreboard;
        sample_t        store[CAPACITY];
        int             held;
        median_result_t owed_q[$];
        int             errors;
        int             checked;

        function new();
            held    = 0;
            errors  = 0;
            checked = 0;
        endfunction

        // an accepted sample: insert it and work out the median it causes
        function void note_sample(sample_t value);
            median_result_t          r;
            int                      pos;
            int                      mid;
            logic signed [MED_W-1:0] upper;
            logic signed [MED_W-1:0] lower;
            r.overflow = (held >= CAPACITY);
            if (!r.overflow) begin
                // equal values end up after the ones already held
                pos = held;
                while (pos > 0 && store[pos-1] > value) begin
                    store[pos] = store[pos-1];
                    pos--;
                end
                store[pos] = value;
                held++;
            end
            mid = held / 2;
            if (held == 0) begin
                r.median_doubled = '0;
            end else if (held % 2 == 1) begin
                upper = store[mid];
                r.median_doubled = upper + upper;
            end else begin
                upper = store[mid];
                lower = store[mid-1];
                r.median_doubled = upper + lower;
            end
            r.sample_count = CNT_W'(held);
            owed_q.insert(owed_q.size(), r);
        endfunction

        function void check_result(logic signed [MED_W-1:0] median_doubled,
                                   logic [CNT_W-1:0] sample_count, logic overflow);
            median_result_t r;
            checked++;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result median_doubled %0d count %0d overflow %0b",
                         $time, median_doubled, sample_count, overflow);
                return;
            end
            r = owed_q.pop_front();
            if (median_doubled !== r.median_doubled) begin
                errors++;
                $display("%0t: median_doubled expected %0d actual %0d",
                         $time, r.median_doubled, median_doubled);
            end
            if (sample_count !== r.sample_count) begin
                errors++;
                $display("%0t: sample_count expected %0d actual %0d",
                         $time, r.sample_count, sample_count);
            end
            if (overflow !== r.overflow) begin
                errors++;
                $display("%0t: overflow expected %0b actual %0b",
                         $time, r.overflow, overflow);
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                    aclk    = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [31:0]      s_sample = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [32:0]      m_median_doubled;
    logic [6:0]              m_sample_count;
    logic                    m_overflow;

    median_scoreboard sb;
    int               cycle_count = 0;
    bit               long_hold_active = 1'b0;
    bit               long_hold_done   = 1'b0;

    running_median_sorted_insert dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_median_doubled (m_median_doubled),
        .m_sample_count   (m_sample_count),
        .m_overflow       (m_overflow)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // watchdog: a hang anywhere ends the run as a failure
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("running_median_sorted_insert test failed");
            $finish;
        end
    end

    // result monitor: values read at the edge are the ones from before it
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_median_doubled, m_sample_count, m_overflow);
        end
    end

    // gap length shared by both sides: mostly none, some short, a few long
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) return 0;
        if (pick < 94) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // sample mix: extremes, a tight cluster for duplicates, and full-range values
    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3: return sample_t'(int'($urandom_range(0, 16)) - 8);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // hold the sample until the block takes it, then tell the scoreboard
    task automatic send_sample(input sample_t value);
        s_valid  <= 1'b1;
        s_sample <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(value);
    endtask

    // drop valid only when a gap actually follows, so valid never glitches
    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // sender stops offering until every owed result has been returned
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
    endtask

    // receiver: random ready pattern plus one long stall early in the run
    initial begin
        int high_len;
        int low_len;
        @(posedge aresetn);
        forever begin
            if (!long_hold_done && sb.checked >= 40) begin
                // sender keeps pushing meanwhile, so the block backs up and stalls
                m_ready          <= 1'b0;
                long_hold_active = 1'b1;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_active = 1'b0;
                long_hold_done   = 1'b1;
            end
            m_ready <= 1'b1;
            high_len = $urandom_range(1, 30);
            repeat (high_len) @(posedge aclk);
            low_len = gap_len();
            if (low_len > 0) begin
                m_ready <= 1'b0;
                repeat (low_len) @(posedge aclk);
            end
        end
    end

    // main sequence: reset, directed samples, random samples, drain, verdict
    initial begin
        sample_t directed[$];
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // both minimum and maximum doubled medians, then mixed signs,
        // runs of equal values and alternating bit patterns
        directed = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0000_0000,
                     32'shFFFF_FFFF, 32'sh0000_0001, 32'sh0000_0005, 32'sh0000_0005,
                     32'sh0000_0005, 32'shFFFF_FFFB, 32'sh5555_5555, 32'shAAAA_AAAA,
                     32'sh0000_0003, 32'shFFFF_FFFE, 32'sh8000_0001, 32'sh7FFF_FFFE,
                     32'sh0000_0004, 32'sh0000_0004};
        foreach (directed[i]) begin
            send_sample(directed[i]);
            idle_sender(gap_len());
        end
        drain_results();

        // random part; the store fills early, after which every sample is refused
        // and the median must hold steady
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_sample(pick_sample());
            if (n == RANDOM_ITEMS / 2) begin
                drain_results();
            end else begin
                idle_sender(long_hold_active ? 0 : gap_len());
            end
        end
        s_valid <= 1'b0;

        while (sb.pending() > 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("running_median_sorted_insert test passed");
        end else begin
            $display("running_median_sorted_insert test failed");
        end
        $finish;
    end

endmodule

[running_median_sorted_insert.f]
rtl/rmsi_pkg.sv
rtl/rmsi_cell.sv
rtl/running_median_sorted_insert.sv
bench/running_median_sorted_insert_tb.sv
